FILE: design/vad_pkg.sv
package vad_pkg;

  localparam int COORD_W    = 16;
  localparam int STAGES     = 16;
  localparam int ANGLE_FRAC = 7;
  localparam int ANGLE_W    = 16;

  // angle accumulator in 1/2^20 degree
  localparam int ZFRAC   = 20;
  localparam int Z_W     = 29;
  localparam int RND_SH  = ZFRAC - ANGLE_FRAC;
  localparam int Q_W     = Z_W - RND_SH;

  // difference vector and CORDIC datapath widths (3 guard bits for gain and fold)
  localparam int DIFF_W  = COORD_W + 1;
  localparam int XY_W    = DIFF_W + STAGES + 3;

  localparam int HALF_TURN = 180 * (2 ** ANGLE_FRAC);
  localparam int FULL_TURN = 2 * HALF_TURN;
  localparam int DEG90_Z   = 90 * (2 ** ZFRAC);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    FOLD_NONE,
    FOLD_POS90,
    FOLD_NEG90
  } fold_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    fold_t                    fold;
    logic                     coin;
  } item_t;

  // atan(2^-i) in degrees, scaled by 2^20
  function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      0:  r = Z_W'(47185920);
      1:  r = Z_W'(27855475);
      2:  r = Z_W'(14718068);
      3:  r = Z_W'(7471121);
      4:  r = Z_W'(3750058);
      5:  r = Z_W'(1876857);
      6:  r = Z_W'(938658);
      7:  r = Z_W'(469357);
      8:  r = Z_W'(234682);
      9:  r = Z_W'(117342);
      10: r = Z_W'(58671);
      11: r = Z_W'(29335);
      12: r = Z_W'(14668);
      13: r = Z_W'(7334);
      14: r = Z_W'(3667);
      15: r = Z_W'(1833);
      16: r = Z_W'(917);
      17: r = Z_W'(458);
      18: r = Z_W'(229);
      19: r = Z_W'(115);
      20: r = Z_W'(57);
      21: r = Z_W'(29);
      22: r = Z_W'(14);
      23: r = Z_W'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/vector_angle_degrees_unit.sv
// An accepted word reaches the output ports through the front register, handoff queue,
// fold stage, 16 CORDIC stages, rounding and output buffer.
// Throughput: one word per cycle unless held; each CORDIC stage is its own register.
// The pipe holds as a whole only while its last result finds the output buffer full.
// Reset (rst, synchronous, active high) empties the front register, the queue,
// the pipe and the output buffer; data registers are not cleared.
module vector_angle_degrees_unit import vad_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [COORD_W-1:0] from_x,
  input  logic signed [COORD_W-1:0] from_y,
  input  logic signed [COORD_W-1:0] to_x,
  input  logic signed [COORD_W-1:0] to_y,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [ANGLE_W-1:0] angle_deg,
  output logic                      points_coincide
);

  // front -> queue
  logic  q_push;
  logic  q_full;
  item_t q_in;

  // queue -> back
  logic  q_pop;
  logic  q_empty;
  item_t q_out;

  // Front: difference vector, coincidence check, quadrant class.
  vad_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .from_x (from_x),
    .from_y (from_y),
    .to_x   (to_x),
    .to_y   (to_y),
    .q_push (q_push),
    .q_full (q_full),
    .q_item (q_in)
  );

  // Short queue so front and back stall independently.
  vad_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_out),
    .empty    (q_empty)
  );

  // Back: fold, CORDIC vectoring pipe, rounding, output buffer.
  vad_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_item          (q_out),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .angle_deg       (angle_deg),
    .points_coincide (points_coincide)
  );

  // A coincident pair always reports a zero angle.
  a_coin_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && points_coincide) |-> (angle_deg == '0))
    else $error("coincident points with nonzero angle");

  // The result is always wrapped into -180..180 degrees.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((angle_deg <= ANGLE_W'(HALF_TURN)) && (angle_deg >= -ANGLE_W'(HALF_TURN))))
    else $error("angle out of range");

  // Backpressure at the input only appears after a word was taken.
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without an accepted word");

  // The back end pops the queue only while it holds a word.
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

FILE: design/vad_front.sv
module vad_front import vad_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [COORD_W-1:0] from_x,
  input  logic signed [COORD_W-1:0] from_y,
  input  logic signed [COORD_W-1:0] to_x,
  input  logic signed [COORD_W-1:0] to_y,
  output logic                      q_push,
  input  logic                      q_full,
  output item_t                     q_item
);

  logic                     front_valid;
  item_t                    front_item;
  logic                     ready;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  item_t                    item_next;

  assign ready  = !front_valid || !q_full;
  assign full   = !ready;
  assign q_push = front_valid && !q_full;
  assign q_item = front_item;

  always_comb begin
    dx = DIFF_W'(to_x) - DIFF_W'(from_x);
    dy = DIFF_W'(to_y) - DIFF_W'(from_y);
    item_next.dx   = dx;
    item_next.dy   = dy;
    item_next.coin = (dx == '0) && (dy == '0);
    if (dx < 0) begin
      item_next.fold = (dy >= 0) ? FOLD_POS90 : FOLD_NEG90;
    end else begin
      item_next.fold = FOLD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (ready) begin
      front_valid <= push;
    end
    if (ready && push) begin
      front_item <= item_next;
    end
  end

endmodule

FILE: design/vad_queue.sv
module vad_queue import vad_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  input  logic  pop,
  output item_t item_out,
  output logic  empty
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
    if (do_push) begin
      mem[wr_ptr] <= item_in;
    end
  end

endmodule

FILE: design/vad_back.sv
module vad_back import vad_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  item_t                     q_item,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic signed [ANGLE_W-1:0] angle_deg,
  output logic                      points_coincide
);

  logic                   advance;
  logic                   v    [STAGES+1];
  logic signed [XY_W-1:0] sx   [STAGES+1];
  logic signed [XY_W-1:0] sy   [STAGES+1];
  logic signed [Z_W-1:0]  sz   [STAGES+1];
  logic                   scoin[STAGES+1];

  logic signed [XY_W-1:0] fold_x;
  logic signed [XY_W-1:0] fold_y;
  logic signed [Z_W-1:0]  fold_z;

  logic                      fin_valid;
  logic signed [ANGLE_W-1:0] fin_angle;
  logic                      fin_coin;

  logic signed [Z_W-1:0]     z_rnd;
  logic signed [Q_W:0]       q_ext;
  logic signed [Q_W:0]       q_wrap;
  logic signed [ANGLE_W-1:0] angle_next;

  logic signed [ANGLE_W-1:0] ob_angle [2];
  logic                      ob_coin  [2];
  logic                      ob_wr;
  logic                      ob_rd;
  logic [1:0]                ob_count;
  logic                      ob_push;
  logic                      ob_pop;

  // whole pipe moves together; holds only when the last result has no room
  assign advance = !(fin_valid && ob_count == 2'd2);
  assign q_pop   = advance && !q_empty;

  // quadrant fold into the right half plane, then scale by 2^STAGES
  always_comb begin
    logic signed [DIFF_W-1:0] fx;
    logic signed [DIFF_W-1:0] fy;
    case (q_item.fold)
      FOLD_POS90: begin
        fx     = q_item.dy;
        fy     = -q_item.dx;
        fold_z = Z_W'(DEG90_Z);
      end
      FOLD_NEG90: begin
        fx     = -q_item.dy;
        fy     = q_item.dx;
        fold_z = -Z_W'(DEG90_Z);
      end
      default: begin
        fx     = q_item.dx;
        fy     = q_item.dy;
        fold_z = '0;
      end
    endcase
    fold_x = {{(XY_W-DIFF_W-STAGES){fx[DIFF_W-1]}}, fx, {STAGES{1'b0}}};
    fold_y = {{(XY_W-DIFF_W-STAGES){fy[DIFF_W-1]}}, fy, {STAGES{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (advance) begin
      v[0] <= !q_empty;
    end
    if (q_pop) begin
      sx[0]    <= fold_x;
      sy[0]    <= fold_y;
      sz[0]    <= fold_z;
      scoin[0] <= q_item.coin;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    assign xs = sx[i] >>> i;
    assign ys = sy[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (advance) begin
        v[i+1] <= v[i];
      end
      if (advance) begin
        scoin[i+1] <= scoin[i];
        if (sy[i] > 0) begin
          sx[i+1] <= sx[i] + ys;
          sy[i+1] <= sy[i] - xs;
          sz[i+1] <= sz[i] + atan_deg(i);
        end else begin
          sx[i+1] <= sx[i] - ys;
          sy[i+1] <= sy[i] + xs;
          sz[i+1] <= sz[i] - atan_deg(i);
        end
      end
    end
  end

  // round to nearest (ties up), wrap into +-180
  always_comb begin
    z_rnd = sz[STAGES] + Z_W'(2 ** (RND_SH - 1));
    q_ext = {z_rnd[Z_W-1], z_rnd[Z_W-1:RND_SH]};
    if (q_ext > (Q_W+1)'(HALF_TURN)) begin
      q_wrap = q_ext - (Q_W+1)'(FULL_TURN);
    end else if (q_ext < -(Q_W+1)'(HALF_TURN)) begin
      q_wrap = q_ext + (Q_W+1)'(FULL_TURN);
    end else begin
      q_wrap = q_ext;
    end
    angle_next = scoin[STAGES] ? '0 : q_wrap[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (advance) begin
      fin_valid <= v[STAGES];
    end
    if (advance) begin
      fin_angle <= angle_next;
      fin_coin  <= scoin[STAGES];
    end
  end

  // two-word output buffer
  assign ob_push = advance && fin_valid;
  assign ob_pop  = pop && !empty;
  assign empty   = (ob_count == 2'd0);

  assign angle_deg       = ob_angle[ob_rd];
  assign points_coincide = ob_coin[ob_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr    <= 1'b0;
      ob_rd    <= 1'b0;
      ob_count <= 2'd0;
    end else begin
      if (ob_push) begin
        ob_wr <= !ob_wr;
      end
      if (ob_pop) begin
        ob_rd <= !ob_rd;
      end
      ob_count <= ob_count + 2'(ob_push) - 2'(ob_pop);
    end
    if (ob_push) begin
      ob_angle[ob_wr] <= fin_angle;
      ob_coin[ob_wr]  <= fin_coin;
    end
  end

endmodule
